>>> rtl/core/assert_macros.svh
// assertion helpers shared by the core files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: property failed");
// condition that must never be seen on a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> rtl/core/bap_pkg.sv
package bap_pkg;

  // field widths
  localparam int CoordW     = 32;
  localparam int AxisW      = 16;
  localparam int SizeW      = 31;
  localparam int ProdW      = CoordW + AxisW;
  localparam int SumW       = 49;
  localparam int NumAxes    = 3;
  localparam int NumCorners = 8;
  localparam int CornerW    = 3;
  localparam int CompW      = 2;

  // stream and configuration widths
  localparam int InDataW  = 144;
  localparam int OutDataW = 200;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [SizeW-1:0] SizeReset = 31'd65536;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgSizeX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSizeY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSizeZ = 2'd2;

  // operation codes
  localparam logic OpSetCenter = 1'b0;
  localparam logic OpProject   = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StIssue,
    StDrain,
    StFinish
  } state_e;

  // control that travels with one product into the mac
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // finished dot product of one corner
  typedef struct packed {
    logic                   valid;
    logic signed [SumW-1:0] sum;
  } mac_out_t;

  // one corner coordinate: center plus or minus half the size, saturated
  function automatic logic signed [CoordW-1:0] corner_coord(
    input logic signed [CoordW-1:0] c,
    input logic        [SizeW-1:0]  size,
    input logic                     plus
  );
    logic signed [CoordW+1:0] ext_c;
    logic signed [CoordW+1:0] half;
    logic signed [CoordW+1:0] sum;
    logic signed [CoordW-1:0] res;
    ext_c = (CoordW+2)'(c);
    half  = (CoordW+2)'(size[SizeW-1:1]);
    sum   = plus ? ext_c + half : ext_c - half;
    if (sum[CoordW+1:CoordW-1] == 3'b000 || sum[CoordW+1:CoordW-1] == 3'b111) begin
      res = sum[CoordW-1:0];
    end else if (sum[CoordW+1]) begin
      res = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      res = {1'b0, {(CoordW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> rtl/core/box_axis_projection_support_core.sv
// channel     | dir | handshake                         | content
// ------------+-----+-----------------------------------+---------------------------------
// s_axis      | in  | s_axis_tvalid / s_axis_tready     | op in tuser, center or axis
// m_axis      | out | m_axis_tvalid / m_axis_tready     | min, max, farthest corner
// cfg         | in  | cfg_valid_i / cfg_ready_o         | box size registers
//
// a set-center word leaves the block idle; a project word holds off the next accept until
// its result is handed to the output register and the block is idle again
// the work is one shared 32x16 multiply-accumulate unit, three products per corner over
// eight corners, fed through the coordinate, product and accumulator registers, then a
// hand-off to the output register and an idle state with ready high
// s_axis_tready is high only while idle; a waiting result holds in the output register
// and stalls the next project word only at its hand-off cycle
// asynchronous active-low reset: sizes to 1.0, center to zero, no result pending
`include "assert_macros.svh"

module box_axis_projection_support_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], axis_x[111:96], axis_y[127:112],
  // axis_z[143:128]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bap_pkg::InDataW-1:0]     s_axis_tdata,
  // op[0]
  input  logic                            s_axis_tuser,
  // proj_min[48:0], proj_max[97:49], far_x[129:98], far_y[161:130], far_z[193:162],
  // far_index[196:194], zero pad[199:197]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bap_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bap_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bap_pkg::CfgDataW-1:0]    cfg_data_i
);
  import bap_pkg::*;

  state_e                   state_d, state_q;
  logic [SizeW-1:0]         size_q [NumAxes];
  logic signed [CoordW-1:0] center_q [NumAxes];
  logic signed [AxisW-1:0]  axis_q [NumAxes];
  logic [CornerW-1:0]       corner_q;
  logic [CompW-1:0]         comp_q;

  logic                     in_acc;
  logic                     issue;
  logic                     issue_end;
  logic                     load_out;
  logic                     cmp_first;
  logic                     cmp_last;

  // coordinate stage in front of the mac
  logic signed [CoordW-1:0] coord_d, coord_q;
  logic signed [AxisW-1:0]  coord_axis_q;
  mac_ctl_t                 coord_ctl_d, coord_ctl_q;
  logic [CompW-1:0]         coord_comp_q;
  logic [CornerW-1:0]       coord_corner_q;

  // coordinates of the corner whose sum is in flight
  logic signed [CoordW-1:0] cc_q [2];
  logic signed [CoordW-1:0] hold_q [NumAxes];
  logic [CornerW-1:0]       hold_idx_q;

  mac_out_t                 mac_out;

  // running extremes
  logic signed [SumW-1:0]   min_q, max_q;
  logic signed [CoordW-1:0] far_q [NumAxes];
  logic [CornerW-1:0]       fidx_q;

  logic                     out_vld_q;
  logic [OutDataW-1:0]      out_data_q;

  assign in_acc      = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign issue       = (state_q == StIssue);
  assign issue_end   = issue && (comp_q == CompW'(NumAxes - 1))
                       && (corner_q == CornerW'(NumCorners - 1));
  assign cmp_first   = (hold_idx_q == '0);
  assign cmp_last    = mac_out.valid && (hold_idx_q == CornerW'(NumCorners - 1));

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_axis_tready = 1'b1;
        if (in_acc && s_axis_tuser == OpProject) begin
          state_d = StIssue;
        end
      end
      StIssue: begin
        if (issue_end) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (cmp_last) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_vld_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // corner and component counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      comp_q   <= '0;
    end else if (state_q == StIdle) begin
      corner_q <= '0;
      comp_q   <= '0;
    end else if (issue) begin
      if (comp_q == CompW'(NumAxes - 1)) begin
        comp_q   <= '0;
        corner_q <= corner_q + 1'b1;
      end else begin
        comp_q <= comp_q + 1'b1;
      end
    end
  end

  // configuration registers and box center
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumAxes; k++) begin
        size_q[k]   <= SizeReset;
        center_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgSizeX: size_q[0] <= cfg_data_i[SizeW-1:0];
          CfgSizeY: size_q[1] <= cfg_data_i[SizeW-1:0];
          CfgSizeZ: size_q[2] <= cfg_data_i[SizeW-1:0];
          default: ;
        endcase
      end
      if (in_acc && s_axis_tuser == OpSetCenter) begin
        center_q[0] <= s_axis_tdata[31:0];
        center_q[1] <= s_axis_tdata[63:32];
        center_q[2] <= s_axis_tdata[95:64];
      end
    end
  end

  // axis captured on a project word
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == OpProject) begin
      axis_q[0] <= s_axis_tdata[111:96];
      axis_q[1] <= s_axis_tdata[127:112];
      axis_q[2] <= s_axis_tdata[143:128];
    end
  end

  // corner coordinate for the current component
  assign coord_d           = corner_coord(center_q[comp_q], size_q[comp_q],
                                          corner_q[2'd2 - comp_q]);
  assign coord_ctl_d.valid = issue;
  assign coord_ctl_d.first = (comp_q == '0);
  assign coord_ctl_d.last  = (comp_q == CompW'(NumAxes - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_ctl_q <= '0;
    end else begin
      coord_ctl_q <= coord_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      coord_q        <= coord_d;
      coord_axis_q   <= axis_q[comp_q];
      coord_comp_q   <= comp_q;
      coord_corner_q <= corner_q;
    end
  end

  // keep the corner's coordinates until its sum is compared
  always_ff @(posedge clk_i) begin
    if (coord_ctl_q.valid) begin
      if (coord_ctl_q.last) begin
        hold_q[0]  <= cc_q[0];
        hold_q[1]  <= cc_q[1];
        hold_q[2]  <= coord_q;
        hold_idx_q <= coord_corner_q;
      end else begin
        cc_q[coord_comp_q[0]] <= coord_q;
      end
    end
  end

  bap_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (coord_ctl_q),
    .coord_i (coord_q),
    .axis_i  (coord_axis_q),
    .out_o   (mac_out)
  );

  // min, max and first farthest corner
  always_ff @(posedge clk_i) begin
    if (mac_out.valid) begin
      if (cmp_first || mac_out.sum < min_q) begin
        min_q <= mac_out.sum;
      end
      if (cmp_first || mac_out.sum > max_q) begin
        max_q  <= mac_out.sum;
        far_q  <= hold_q;
        fidx_q <= hold_idx_q;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {3'b000, fidx_q, far_q[2], far_q[1], far_q[0], max_q, min_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  `ASSERT_CLK(a_mac_busy, clk_i, rst_ni, mac_out.valid |-> (state_q == StIssue || state_q == StDrain))
  `ASSERT_CLK(a_finish_after_last, clk_i, rst_ni, (state_q == StFinish && $past(state_q) == StDrain) |-> $past(cmp_last))
  `ASSERT_CLK(a_min_le_max, clk_i, rst_ni, (state_q == StFinish) |-> (min_q <= max_q))
  `ASSERT_NEVER(a_no_coord_idle, clk_i, rst_ni, coord_ctl_q.valid && state_q == StIdle)

endmodule

>>> rtl/core/bap_mac.sv
`include "assert_macros.svh"

module bap_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bap_pkg::mac_ctl_t                    ctl_i,
  input  logic signed [bap_pkg::CoordW-1:0]    coord_i,
  input  logic signed [bap_pkg::AxisW-1:0]     axis_i,
  output bap_pkg::mac_out_t                    out_o
);
  import bap_pkg::*;

  logic signed [ProdW-1:0] coord_ext;
  logic signed [ProdW-1:0] axis_ext;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic                    prod_vld_q, prod_first_q, prod_last_q;
  logic signed [SumW-1:0]  acc_d, acc_q;
  logic                    acc_vld_q;

  // multiply stage
  assign coord_ext = ProdW'(coord_i);
  assign axis_ext  = ProdW'(axis_i);
  assign prod_d    = coord_ext * axis_ext;

  // accumulate stage, cleared by the first product of a corner
  assign acc_d = (prod_first_q ? '0 : acc_q) + SumW'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q   <= 1'b0;
      prod_first_q <= 1'b0;
      prod_last_q  <= 1'b0;
      acc_vld_q    <= 1'b0;
    end else begin
      prod_vld_q   <= ctl_i.valid;
      prod_first_q <= ctl_i.first;
      prod_last_q  <= ctl_i.last;
      acc_vld_q    <= prod_vld_q & prod_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= prod_d;
    end
    if (prod_vld_q) begin
      acc_q <= acc_d;
    end
  end

  assign out_o.valid = acc_vld_q;
  assign out_o.sum   = acc_q;

  // a finished sum follows the last product of its corner through the product and accumulator registers
  `ASSERT_CLK(a_sum_after_last, clk_i, rst_ni, acc_vld_q |-> $past(ctl_i.valid && ctl_i.last, 2))
  `ASSERT_CLK(a_first_clears, clk_i, rst_ni, (prod_vld_q && prod_first_q) |=> (acc_q == SumW'($past(prod_q))))
  `ASSERT_NEVER(a_first_and_last, clk_i, rst_ni, ctl_i.valid && ctl_i.first && ctl_i.last)

endmodule

>>> test/box_axis_projection_support_core_test.sv
`timescale 1ns / 100ps

module box_axis_projection_support_core_test;
  import bap_pkg::*;

  localparam int unsigned DrainCycles = 40;
  localparam int unsigned ItemsPerPhase = 400;
  localparam int unsigned NumPhases = 5;
  localparam longint CoordMax = 64'sd2147483647;
  localparam longint CoordMin = -64'sd2147483648;
  // index past the last size register, writes to it are dropped
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  // one expected projection word
  typedef struct packed {
    logic [SumW-1:0]    pmin;
    logic [SumW-1:0]    pmax;
    logic [CoordW-1:0]  fx;
    logic [CoordW-1:0]  fy;
    logic [CoordW-1:0]  fz;
    logic [CornerW-1:0] fi;
  } proj_res_t;

  // box model and queue of projections still to come out
  class proj_scoreboard;
    logic [SizeW-1:0]         size_q[NumAxes];
    logic signed [CoordW-1:0] ctr[NumAxes];
    proj_res_t                proj_q[$];
    int unsigned              errors;

    function new();
      int a;
      for (a = 0; a < NumAxes; a++) begin
        size_q[a] = SizeReset;
        ctr[a] = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgSizeX: size_q[0] = data[SizeW-1:0];
        CfgSizeY: size_q[1] = data[SizeW-1:0];
        CfgSizeZ: size_q[2] = data[SizeW-1:0];
        default: ;
      endcase
    endfunction

    // center plus or minus half the size, clamped to 32 bits
    function longint corner_at(int a, bit plus);
      longint h;
      longint v;
      h = longint'(size_q[a] >> 1);
      v = plus ? longint'(ctr[a]) + h : longint'(ctr[a]) - h;
      if (v > CoordMax) v = CoordMax;
      else if (v < CoordMin) v = CoordMin;
      return v;
    endfunction

    function void note_word(logic op, logic [InDataW-1:0] data);
      longint    ax[NumAxes];
      longint    cc[NumAxes];
      longint    p;
      longint    lo;
      longint    hi;
      proj_res_t r;
      int        i;
      int        a;
      if (op == OpSetCenter) begin
        ctr[0] = data[31:0];
        ctr[1] = data[63:32];
        ctr[2] = data[95:64];
        return;
      end
      ax[0] = longint'($signed(data[111:96]));
      ax[1] = longint'($signed(data[127:112]));
      ax[2] = longint'($signed(data[143:128]));
      lo = 0;
      hi = 0;
      r = '0;
      // walk the corners, lowest index keeps ties
      for (i = 0; i < NumCorners; i++) begin
        for (a = 0; a < NumAxes; a++) begin
          cc[a] = corner_at(a, i[2-a]);
        end
        p = cc[0] * ax[0] + cc[1] * ax[1] + cc[2] * ax[2];
        if (i == 0 || p < lo) lo = p;
        if (i == 0 || p > hi) begin
          hi = p;
          r.fx = CoordW'(cc[0]);
          r.fy = CoordW'(cc[1]);
          r.fz = CoordW'(cc[2]);
          r.fi = CornerW'(i);
        end
      end
      r.pmin = SumW'(lo);
      r.pmax = SumW'(hi);
      proj_q.insert(proj_q.size(), r);
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_word(logic [OutDataW-1:0] data);
      proj_res_t e;
      if (proj_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual %h", $time, data);
        return;
      end
      e = proj_q.pop_front();
      cmp("proj_min", 64'(e.pmin), 64'(data[48:0]));
      cmp("proj_max", 64'(e.pmax), 64'(data[97:49]));
      cmp("far_x", 64'(e.fx), 64'(data[129:98]));
      cmp("far_y", 64'(e.fy), 64'(data[161:130]));
      cmp("far_z", 64'(e.fz), 64'(data[193:162]));
      cmp("far_index", 64'(e.fi), 64'(data[196:194]));
    endfunction

    function bit pending();
      return proj_q.size() != 0;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic [15:0]         stall_pat = 16'hffff;
  int unsigned         pat_age = 0;

  proj_scoreboard board = new();

  box_axis_projection_support_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk = ~clk;

  // receiver stalls on a rotating pattern, reloaded now and then
  always @(posedge clk) begin
    if (pat_age == 63) begin
      pat_age <= 0;
      if ($urandom_range(0, 3) == 0) stall_pat <= 16'hffff;
      else stall_pat <= 16'($urandom) | 16'h0001;
    end else begin
      pat_age <= pat_age + 1;
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    end
    m_axis_tready <= stall_pat[0];
  end

  // result word taken at the coming edge, values are stable at the falling edge
  always @(negedge clk) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
  end

  // present one word and hold it until taken
  task automatic send_word(input logic op, input logic [InDataW-1:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= data;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    board.note_word(op, data);
  endtask

  task automatic pause_input(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold the sender until every projection is out and the block is idle
  task automatic drain_results();
    pause_input(1);
    while (board.pending()) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk);
    while (!cfg_ready_o) @(negedge clk);
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk);
  endtask

  // position fields are don't-care here, so fill them with noise
  task automatic project(input logic [AxisW-1:0] ax, input logic [AxisW-1:0] ay,
                         input logic [AxisW-1:0] az);
    send_word(OpProject, {az, ay, ax, 32'($urandom), 32'($urandom), 32'($urandom)});
  endtask

  // axis fields are don't-care here
  task automatic set_center(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                            input logic [CoordW-1:0] z);
    send_word(OpSetCenter, {16'($urandom), 16'($urandom), 16'($urandom), z, y, x});
  endtask

  // centers lean toward the rails so corners clamp often
  function automatic logic [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h7fffffff - 32'($urandom_range(0, 1 << 20));
      3: return 32'h80000000 + 32'($urandom_range(0, 1 << 20));
      default: return 32'($urandom);
    endcase
  endfunction

  // bit 31 is outside the register and is sent random
  function automatic logic [CfgDataW-1:0] pick_size();
    logic [CfgDataW-1:0] top;
    top = {$urandom_range(0, 1) == 1, 31'd0};
    case ($urandom_range(0, 4))
      0: return top;
      1: return top | 32'h7fffffff;
      2: return top | 32'($urandom_range(0, 1 << 20));
      default: return 32'($urandom);
    endcase
  endfunction

  // simple axes give equal projections and exercise the tie rule
  function automatic logic [AxisW-1:0] pick_axis();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h4000;
      2: return 16'h8000;
      3: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned burst_left;
    int unsigned gap;

    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // unit box at the origin, unit axes, zero axis and partial ties
    project(16'h4000, 16'h0000, 16'h0000);
    project(16'h0000, 16'h4000, 16'h0000);
    project(16'h0000, 16'h0000, 16'h4000);
    project(16'h0000, 16'h0000, 16'h0000);
    project(16'h4000, 16'h4000, 16'h0000);
    project(16'h8000, 16'h8000, 16'h8000);
    project(16'h7fff, 16'h7fff, 16'h7fff);
    // centers on the rails so the corners clamp
    set_center(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    project(16'h7fff, 16'h8000, 16'h0001);
    set_center(32'h80000000, 32'h80000000, 32'h80000000);
    project(16'h8000, 16'h7fff, 16'hffff);

    // largest sizes, bit 31 set on one write, dropped write past the last register
    drain_results();
    cfg_write(CfgSizeX, 32'hffffffff);
    cfg_write(CfgSizeY, 32'h7fffffff);
    cfg_write(CfgSizeZ, 32'h7ffffffe);
    cfg_write(CfgNoReg, 32'($urandom));
    project(16'h7fff, 16'h7fff, 16'h7fff);
    set_center(32'h00000000, 32'h00000000, 32'h00000000);
    project(16'h8000, 16'h8000, 16'h8000);
    set_center(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    project(16'hffff, 16'hffff, 16'hffff);

    // zero sizes, all corners coincide
    drain_results();
    cfg_write(CfgSizeX, 32'h00000000);
    cfg_write(CfgSizeY, 32'h00000000);
    cfg_write(CfgSizeZ, 32'h80000000);
    project(16'($urandom), 16'($urandom), 16'($urandom));
    set_center(32'($urandom), 32'($urandom), 32'($urandom));
    project(16'($urandom), 16'($urandom), 16'($urandom));

    // random phases, each with its own box sizes
    for (phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      if (phase == 0 || $urandom_range(0, 2) != 0) cfg_write(CfgSizeX, pick_size());
      if (phase == 0 || $urandom_range(0, 2) != 0) cfg_write(CfgSizeY, pick_size());
      if (phase == 0 || $urandom_range(0, 2) != 0) cfg_write(CfgSizeZ, pick_size());
      if ($urandom_range(0, 1) == 1) cfg_write(CfgNoReg, 32'($urandom));
      burst_left = $urandom_range(1, 24);
      for (n = 0; n < ItemsPerPhase; n++) begin
        // sender holds off until the output side has caught up
        if (n == ItemsPerPhase / 2) drain_results();
        if ($urandom_range(0, 3) == 0) set_center(pick_coord(), pick_coord(), pick_coord());
        else project(pick_axis(), pick_axis(), pick_axis());
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = $urandom_range(0, 12);
          if (gap != 0) pause_input(gap);
        end else begin
          burst_left--;
        end
      end
    end

    drain_results();
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/bap_pkg.sv
rtl/core/bap_mac.sv
rtl/core/box_axis_projection_support_core.sv
test/box_axis_projection_support_core_test.sv
